// File: sv/message_match_queue_core_macros.svh
// Assertion macros for the message match queue checker
`ifndef MESSAGE_MATCH_QUEUE_CORE_MACROS_SVH
`define MESSAGE_MATCH_QUEUE_CORE_MACROS_SVH
// assert that a condition implies a consequence in the same cycle
`define MMQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// assert that a condition implies a consequence in the next cycle
`define MMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: sv/mmq_pkg.sv
// Package of types and constants for the message match queue
package mmq_pkg;
    localparam int NUM_RANKS   = 16;
    localparam int QUEUE_DEPTH = 16;
    localparam int RANK_W  = $clog2(NUM_RANKS);
    localparam int SLOT_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W  = RANK_W + SLOT_W;
    localparam int ENTRIES = NUM_RANKS * (1 << SLOT_W);

    localparam logic [1:0] OP_ARRIVE = 2'd0;
    localparam logic [1:0] OP_RECV   = 2'd1;
    localparam logic [1:0] OP_LEFT   = 2'd2;

    localparam logic [2:0] ST_DELIVERED = 3'd0;
    localparam logic [2:0] ST_PENDING   = 3'd1;
    localparam logic [2:0] ST_REMOTE    = 3'd2;
    localparam logic [2:0] ST_SELF      = 3'd3;
    localparam logic [2:0] ST_NO_RANK   = 3'd4;
    localparam logic [2:0] ST_QUEUED    = 3'd5;
    localparam logic [2:0] ST_DROPPED   = 3'd6;
    localparam logic [2:0] ST_NOTED     = 3'd7;

    localparam logic CFG_OWN_RANK   = 1'b0;
    localparam logic CFG_WORLD_SIZE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [77:0] data;
    } entry_t;
endpackage

// File: sv/message_match_queue_core.sv
// Top level of the message match queue engine
// Arrivals, source-left events and refused receives register their result
// from the first scan state. A receive steps through its source queue one
// entry at a time, reading then checking each on the single entry memory port
// pair, then closes up the queue behind the taken entry, reading and writing
// back each later entry in turn. The result register holds the outcome until
// it is transferred, and the block is ready again in the cycle after that, so
// it takes one item at a time.
// No clearing pass is needed after reset.
module message_match_queue_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [3:0]  source,
    input  logic [30:0] tag,
    input  logic [30:0] count,
    input  logic [15:0] buffer_handle,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [15:0] result_handle,
    output logic [30:0] result_tag,
    output logic [3:0]  result_source,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data
);
    localparam int RW = mmq_pkg::RANK_W;
    localparam int SW = mmq_pkg::SLOT_W;
    localparam int FW = mmq_pkg::FILL_W;
    localparam int AW = mmq_pkg::ADDR_W;

    mmq_pkg::state_t state_reg, state_next;

    logic [3:0]  own_rank_reg;
    logic [4:0]  world_size_reg;
    logic [FW-1:0] fill_reg [mmq_pkg::NUM_RANKS];
    logic [mmq_pkg::NUM_RANKS-1:0] finished_reg;
    logic        pend_valid_reg;
    logic [3:0]  pend_source_reg;
    logic [30:0] pend_tag_reg, pend_count_reg;

    // captured item
    logic [1:0]  op_reg;
    logic [3:0]  src_reg;
    logic [30:0] tag_reg, count_reg;
    logic [15:0] handle_reg;
    logic [FW-1:0] idx_reg, idx_next;

    logic [2:0]  status_reg;
    logic [15:0] rhandle_reg;
    logic [30:0] rtag_reg;

    // entry memory
    logic [77:0] mem [mmq_pkg::ENTRIES];
    logic [77:0] rd_data_reg;
    logic        rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [77:0] wr_data;

    logic in_fire, out_fire;
    logic src_ok;
    logic [RW-1:0] src_idx;
    logic [FW-1:0] cur_fill;
    logic arr_match, ent_match;
    logic [30:0] e_tag, e_count;
    logic [15:0] e_handle;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;
    assign in_ready  = (state_reg == mmq_pkg::S_IDLE);
    assign out_valid = (state_reg == mmq_pkg::S_OUT);
    assign status = status_reg;
    assign result_handle = rhandle_reg;
    assign result_tag = rtag_reg;
    assign result_source = src_reg;

    assign src_ok  = ({1'b0, src_reg} < 5'(mmq_pkg::NUM_RANKS));
    assign src_idx = src_reg[RW-1:0];
    assign cur_fill = fill_reg[src_idx];
    assign e_tag    = rd_data_reg[77:47];
    assign e_count  = rd_data_reg[46:16];
    assign e_handle = rd_data_reg[15:0];
    assign arr_match = pend_valid_reg && (pend_source_reg == src_reg)
        && ((tag_reg == pend_tag_reg) || (pend_tag_reg == 31'd0))
        && (count_reg == pend_count_reg);
    assign ent_match = ((e_tag == tag_reg) || (tag_reg == 31'd0)) && (e_count == count_reg);

    // memory port pair
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_rank_reg   <= 4'd0;
            world_size_reg <= 5'd16;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mmq_pkg::CFG_OWN_RANK:   own_rank_reg   <= cfg_data[3:0];
                mmq_pkg::CFG_WORLD_SIZE: world_size_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mmq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // capture the item and the index
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg     <= op;
            src_reg    <= source;
            tag_reg    <= tag;
            count_reg  <= count;
            handle_reg <= buffer_handle;
        end
        idx_reg <= idx_next;
    end

    // sequencer and control state
    logic set_res;
    logic [2:0] res_st;
    logic [15:0] res_h;
    logic [30:0] res_t;
    logic fill_inc, fill_dec, pend_clr, pend_set, fin_set;

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        rd_en = 1'b0;
        wr_en = 1'b0;
        rd_addr = {src_idx, idx_reg[SW-1:0]};
        wr_addr = {src_idx, idx_reg[SW-1:0]};
        wr_data = {tag_reg, count_reg, handle_reg};
        set_res = 1'b0;
        res_st = mmq_pkg::ST_NOTED;
        res_h = 16'd0;
        res_t = 31'd0;
        fill_inc = 1'b0;
        fill_dec = 1'b0;
        pend_clr = 1'b0;
        pend_set = 1'b0;
        fin_set = 1'b0;
        case (state_reg)
            mmq_pkg::S_IDLE:
            begin
                idx_next = '0;
                if (in_fire)
                begin
                    state_next = mmq_pkg::S_SCAN_RD;
                end
            end
            mmq_pkg::S_SCAN_RD:
            begin
                // first visit decides simple ops
                state_next = mmq_pkg::S_OUT;
                set_res = 1'b1;
                if (op_reg == mmq_pkg::OP_ARRIVE)
                begin
                    if (!src_ok)
                    begin
                        res_st = mmq_pkg::ST_NO_RANK;
                    end
                    else if (arr_match)
                    begin
                        pend_clr = 1'b1;
                        res_st = mmq_pkg::ST_DELIVERED;
                        res_h = handle_reg;
                        res_t = tag_reg;
                    end
                    else if (cur_fill >= FW'(mmq_pkg::QUEUE_DEPTH))
                    begin
                        res_st = mmq_pkg::ST_DROPPED;
                    end
                    else
                    begin
                        wr_en = 1'b1;
                        wr_addr = {src_idx, cur_fill[SW-1:0]};
                        fill_inc = 1'b1;
                        res_st = mmq_pkg::ST_QUEUED;
                    end
                end
                else if (op_reg == mmq_pkg::OP_RECV)
                begin
                    if (src_reg == own_rank_reg)
                    begin
                        res_st = mmq_pkg::ST_SELF;
                    end
                    else if (!src_ok || ({1'b0, src_reg} >= world_size_reg))
                    begin
                        res_st = mmq_pkg::ST_NO_RANK;
                    end
                    else if (idx_reg < cur_fill)
                    begin
                        set_res = 1'b0;
                        rd_en = 1'b1;
                        state_next = mmq_pkg::S_SCAN_CHK;
                    end
                    else if (finished_reg[src_idx])
                    begin
                        pend_clr = 1'b1;
                        res_st = mmq_pkg::ST_REMOTE;
                    end
                    else
                    begin
                        pend_set = 1'b1;
                        res_st = mmq_pkg::ST_PENDING;
                    end
                end
                else if (op_reg == mmq_pkg::OP_LEFT)
                begin
                    if (!src_ok)
                    begin
                        res_st = mmq_pkg::ST_NO_RANK;
                    end
                    else
                    begin
                        fin_set = 1'b1;
                        if (pend_valid_reg && (pend_source_reg == src_reg))
                        begin
                            pend_clr = 1'b1;
                            res_st = mmq_pkg::ST_REMOTE;
                        end
                    end
                end
            end
            mmq_pkg::S_SCAN_CHK:
            begin
                if (ent_match)
                begin
                    set_res = 1'b1;
                    res_st = mmq_pkg::ST_DELIVERED;
                    res_h = e_handle;
                    res_t = e_tag;
                    pend_clr = 1'b1;
                    state_next = mmq_pkg::S_SHIFT_RD;
                end
                else
                begin
                    idx_next = idx_reg + FW'(1);
                    state_next = mmq_pkg::S_SCAN_RD;
                end
            end
            mmq_pkg::S_SHIFT_RD:
            begin
                // close up: move entry idx+1 down to idx
                if ((idx_reg + FW'(1)) < cur_fill)
                begin
                    rd_en = 1'b1;
                    rd_addr = {src_idx, SW'(idx_reg + FW'(1))};
                    state_next = mmq_pkg::S_SHIFT_WR;
                end
                else
                begin
                    fill_dec = 1'b1;
                    state_next = mmq_pkg::S_OUT;
                end
            end
            mmq_pkg::S_SHIFT_WR:
            begin
                wr_en = 1'b1;
                wr_data = rd_data_reg;
                idx_next = idx_reg + FW'(1);
                state_next = mmq_pkg::S_SHIFT_RD;
            end
            mmq_pkg::S_OUT:
            begin
                if (out_fire)
                begin
                    state_next = mmq_pkg::S_IDLE;
                end
            end
            default: state_next = mmq_pkg::S_IDLE;
        endcase
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (set_res)
        begin
            status_reg  <= res_st;
            rhandle_reg <= res_h;
            rtag_reg    <= res_t;
        end
    end

    // queue fill, finished marks and the pending receive
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < mmq_pkg::NUM_RANKS; r++)
            begin
                fill_reg[r] <= '0;
            end
            finished_reg    <= '0;
            pend_valid_reg  <= 1'b0;
            pend_source_reg <= 4'd0;
            pend_tag_reg    <= 31'd0;
            pend_count_reg  <= 31'd0;
        end
        else
        begin
            if (fill_inc)
            begin
                fill_reg[src_idx] <= cur_fill + FW'(1);
            end
            else if (fill_dec)
            begin
                fill_reg[src_idx] <= cur_fill - FW'(1);
            end
            if (fin_set)
            begin
                finished_reg[src_idx] <= 1'b1;
            end
            if (pend_set)
            begin
                pend_valid_reg  <= 1'b1;
                pend_source_reg <= src_reg;
                pend_tag_reg    <= tag_reg;
                pend_count_reg  <= count_reg;
            end
            else if (pend_clr)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end
endmodule

// File: sv/mmq_checker.sv
// Port checker for the message match queue, bound to the top level
`include "message_match_queue_core_macros.svh"
module mmq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [15:0] result_handle,
    input logic [30:0] result_tag,
    input logic [3:0]  result_source
);
    // one item in flight: never ready while a result waits
    `MMQ_ASSERT_IMPL(a_excl, clk, rst_n, out_valid, !in_ready, "ready while result waits")
    // a transfer in gives no result in the cycle after
    `MMQ_ASSERT_NEXT(a_no_early, clk, rst_n, in_valid && in_ready, !out_valid, "result too early")
    // only a delivery carries a handle or a tag
    `MMQ_ASSERT_IMPL(a_zero, clk, rst_n, out_valid && (status != mmq_pkg::ST_DELIVERED),
        (result_handle == 16'd0) && (result_tag == 31'd0), "payload on failure")
    // a stalled result holds
    `MMQ_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(status) && $stable(result_source), "result changed")
endmodule

bind message_match_queue_core mmq_checker u_mmq_checker (.*);

// File: sim/message_match_queue_core_checker.sv
// Checker for the message match queue: predicts every result and compares it
module message_match_queue_core_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  op,
    input  logic [3:0]  source,
    input  logic [30:0] tag,
    input  logic [30:0] count,
    input  logic [15:0] buffer_handle,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  status,
    input  logic [15:0] result_handle,
    input  logic [30:0] result_tag,
    input  logic [3:0]  result_source,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data,
    output int          fail_count,
    output int          outstanding,
    output int          delivered_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]  st;
        logic [15:0] hnd;
        logic [30:0] tg;
        logic [3:0]  src;
    } outcome_t;

    logic [30:0] q_tag [mmq_pkg::NUM_RANKS][mmq_pkg::QUEUE_DEPTH];
    logic [30:0] q_cnt [mmq_pkg::NUM_RANKS][mmq_pkg::QUEUE_DEPTH];
    logic [15:0] q_hnd [mmq_pkg::NUM_RANKS][mmq_pkg::QUEUE_DEPTH];
    int          q_fill [mmq_pkg::NUM_RANKS];
    logic        gone [mmq_pkg::NUM_RANKS];
    logic        wait_valid;
    logic [3:0]  wait_src;
    logic [30:0] wait_tag;
    logic [30:0] wait_cnt;
    logic [3:0]  my_rank;
    logic [4:0]  ranks_used;
    outcome_t    expected_q [$];

    assign outstanding = expected_q.size();

    function automatic bit fits(logic [30:0] ht, logic [30:0] hc,
                                logic [30:0] wt, logic [30:0] wc);
        return (ht == wt || wt == 31'd0) && hc == wc;
    endfunction

    // Advance the shadow state by one item and return its outcome
    function automatic outcome_t match_step(logic [1:0] o, logic [3:0] s,
                                            logic [30:0] t, logic [30:0] c,
                                            logic [15:0] h);
        outcome_t r;
        int f;
        r = '{st: mmq_pkg::ST_NOTED, hnd: 16'd0, tg: 31'd0, src: s};
        if (o == mmq_pkg::OP_ARRIVE)
        begin
            if (wait_valid && wait_src == s && fits(t, c, wait_tag, wait_cnt))
            begin
                wait_valid = 1'b0;
                r.st = mmq_pkg::ST_DELIVERED; r.hnd = h; r.tg = t;
            end
            else if (q_fill[s] >= mmq_pkg::QUEUE_DEPTH)
            begin
                r.st = mmq_pkg::ST_DROPPED;
            end
            else
            begin
                f = q_fill[s];
                q_tag[s][f] = t; q_cnt[s][f] = c; q_hnd[s][f] = h;
                q_fill[s] = f + 1;
                r.st = mmq_pkg::ST_QUEUED;
            end
        end
        else if (o == mmq_pkg::OP_RECV)
        begin
            if (s == my_rank) r.st = mmq_pkg::ST_SELF;
            else if ({1'b0, s} >= ranks_used) r.st = mmq_pkg::ST_NO_RANK;
            else
            begin
                f = q_fill[s];
                for (int i = 0; i < f; i++)
                begin
                    if (r.st == mmq_pkg::ST_NOTED &&
                        fits(q_tag[s][i], q_cnt[s][i], t, c))
                    begin
                        r.st = mmq_pkg::ST_DELIVERED;
                        r.hnd = q_hnd[s][i]; r.tg = q_tag[s][i];
                        for (int j = i; j + 1 < f; j++)
                        begin
                            q_tag[s][j] = q_tag[s][j+1];
                            q_cnt[s][j] = q_cnt[s][j+1];
                            q_hnd[s][j] = q_hnd[s][j+1];
                        end
                        q_fill[s] = f - 1;
                        wait_valid = 1'b0;
                    end
                end
                if (r.st == mmq_pkg::ST_NOTED)
                begin
                    if (gone[s])
                    begin
                        wait_valid = 1'b0;
                        r.st = mmq_pkg::ST_REMOTE;
                    end
                    else
                    begin
                        wait_valid = 1'b1; wait_src = s; wait_tag = t; wait_cnt = c;
                        r.st = mmq_pkg::ST_PENDING;
                    end
                end
            end
        end
        else if (o == mmq_pkg::OP_LEFT)
        begin
            gone[s] = 1'b1;
            if (wait_valid && wait_src == s)
            begin
                wait_valid = 1'b0;
                r.st = mmq_pkg::ST_REMOTE;
            end
        end
        return r;
    endfunction

    // Predict on input transfers, compare on output transfers
    always @(posedge clk or negedge rst_n)
    begin
        outcome_t e;
        if (!rst_n)
        begin
            for (int k = 0; k < mmq_pkg::NUM_RANKS; k++)
            begin
                q_fill[k] = 0; gone[k] = 1'b0;
            end
            wait_valid = 1'b0; wait_src = '0; wait_tag = '0; wait_cnt = '0;
            my_rank = '0; ranks_used = 5'd16;
            expected_q.delete();
            fail_count = 0; delivered_seen = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result status=%0d", $time, status);
                    fail_count++;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (status == mmq_pkg::ST_DELIVERED) delivered_seen++;
                    if (status !== e.st || result_handle !== e.hnd ||
                        result_tag !== e.tg || result_source !== e.src)
                    begin
                        $display("%0t: mismatch expected st=%0d h=%h t=%h s=%0d",
                                 $time, e.st, e.hnd, e.tg, e.src);
                        $display("%0t:          got      st=%0d h=%h t=%h s=%0d",
                                 $time, status, result_handle, result_tag, result_source);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_q.insert(expected_q.size(),
                                  match_step(op, source, tag, count, buffer_handle));
            if (cfg_we)
            begin
                if (cfg_index == mmq_pkg::CFG_OWN_RANK) my_rank = cfg_data[3:0];
                else ranks_used = cfg_data;
            end
        end
    end
endmodule

// File: sim/message_match_queue_core_tb.sv
// Testbench top: stimulus, idling schedule and verdict for the match queue
module message_match_queue_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // op value outside the three defined operations
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  op = '0;
    logic [3:0]  source = '0;
    logic [30:0] tag = '0;
    logic [30:0] count = '0;
    logic [15:0] buffer_handle = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [15:0] result_handle;
    logic [30:0] result_tag;
    logic [3:0]  result_source;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [4:0]  cfg_data = '0;
    int          fail_count;
    int          outstanding;
    int          delivered_seen;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          hold_off = 1'b0;
    int          items_sent = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    message_match_queue_core u_top (.*);
    message_match_queue_core_checker u_chk (.*);

    // Receiver: idle at random, or hold off entirely
    always @(negedge clk)
        out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);

    // Offer one item, hold it until the transfer, then drop valid
    task automatic send_item(logic [1:0] o, logic [3:0] s, logic [30:0] t,
                             logic [30:0] c, logic [15:0] h);
        while ($urandom_range(99) < send_idle_pct) @(negedge clk);
        in_valid <= 1'b1; op <= o; source <= s; tag <= t; count <= c;
        buffer_handle <= h;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        in_valid <= 1'b0;
        items_sent++;
        @(negedge clk);
    endtask

    // Drain, then write one register while idle
    task automatic write_cfg(logic idx, logic [4:0] d);
        while (outstanding != 0) @(negedge clk);
        repeat (4 * mmq_pkg::QUEUE_DEPTH + 8) @(negedge clk);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= d;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random items: mostly arrivals and receives on a few tags and counts
    task automatic random_phase(int n);
        logic [1:0]  o;
        logic [3:0]  s;
        logic [30:0] t, c;
        int r;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(99);
            o = (r < 50) ? mmq_pkg::OP_ARRIVE : (r < 93) ? mmq_pkg::OP_RECV :
                (r < 98) ? mmq_pkg::OP_LEFT : OP_UNUSED;
            s = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(3));
            t = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(3));
            c = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(2));
            send_item(o, s, t, c, 16'($urandom));
        end
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        write_cfg(mmq_pkg::CFG_OWN_RANK, 5'd0);
        write_cfg(mmq_pkg::CFG_WORLD_SIZE, 5'd16);
        // Directed: extremes, refusals, pending, fill, drop, source left
        send_item(mmq_pkg::OP_RECV, 4'd0, 31'd5, 31'd5, 16'd0);
        send_item(mmq_pkg::OP_RECV, 4'd15, 31'h7fffffff, 31'h7fffffff, 16'hffff);
        send_item(mmq_pkg::OP_ARRIVE, 4'd15, 31'h7fffffff, 31'h7fffffff, 16'hffff);
        send_item(mmq_pkg::OP_ARRIVE, 4'd3, 31'd1, 31'd0, 16'h1234);
        for (int k = 0; k < 16; k++)
            send_item(mmq_pkg::OP_ARRIVE, 4'd2, 31'(k + 1), 31'd7, 16'(k));
        send_item(mmq_pkg::OP_ARRIVE, 4'd2, 31'd9, 31'd7, 16'hbeef);
        send_item(mmq_pkg::OP_RECV, 4'd2, 31'd0, 31'd7, 16'd0);
        send_item(mmq_pkg::OP_RECV, 4'd2, 31'd16, 31'd7, 16'd0);
        send_item(mmq_pkg::OP_RECV, 4'd4, 31'd3, 31'd3, 16'd0);
        send_item(mmq_pkg::OP_ARRIVE, 4'd4, 31'd3, 31'd3, 16'h5555);
        send_item(mmq_pkg::OP_RECV, 4'd5, 31'd3, 31'd3, 16'd0);
        send_item(mmq_pkg::OP_LEFT, 4'd5, 31'd0, 31'd0, 16'd0);
        send_item(mmq_pkg::OP_RECV, 4'd5, 31'd3, 31'd3, 16'd0);
        send_item(mmq_pkg::OP_ARRIVE, 4'd5, 31'd3, 31'd3, 16'h0aaa);
        send_item(mmq_pkg::OP_LEFT, 4'd6, 31'd0, 31'd0, 16'd0);
        send_item(OP_UNUSED, 4'd7, 31'd0, 31'd0, 16'd0);
        // Pressure: hold the receiver off while items keep coming
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(negedge clk);
                hold_off = 1'b0;
            end
            random_phase(20);
        join
        send_idle_pct = 13; recv_idle_pct = 80;
        random_phase(620);
        write_cfg(mmq_pkg::CFG_OWN_RANK, 5'd15);
        write_cfg(mmq_pkg::CFG_WORLD_SIZE, 5'd1);
        send_idle_pct = 80; recv_idle_pct = 13;
        random_phase(620);
        write_cfg(mmq_pkg::CFG_OWN_RANK, 5'd1);
        write_cfg(mmq_pkg::CFG_WORLD_SIZE, 5'd4);
        send_idle_pct = 0; recv_idle_pct = 0;
        random_phase(650);
        while (outstanding != 0) @(negedge clk);
        repeat (4 * mmq_pkg::QUEUE_DEPTH + 8) @(negedge clk);
        $display("Sent %0d items over three idling schedules and three register settings;",
                 items_sent);
        $display("%0d receives or arrivals were delivered.", delivered_seen);
        if (fail_count == 0 && outstanding == 0)
            $display("message_match_queue_core_tb passed");
        else
            $display("message_match_queue_core_tb failed");
        $finish;
    end

    // Guard against a hang
    initial
    begin
        #2000000;
        $display("message_match_queue_core_tb failed");
        $finish;
    end
endmodule
